// File: hdl/brl_pkg.sv
// Shared constants and operation codes for the line rasterizer.
`default_nettype none

package brl_pkg;

    // Width of the color carried with each line
    localparam int COLOR_BITS = 24;

    // Item kind carried on the input tuser bit
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

endpackage

`default_nettype wire

// File: hdl/brl_in_stage.sv
// Input register: captures one item and splits tdata into its fields.
`default_nettype none

module brl_in_stage
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DATA_W     = 88
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [DATA_W-1:0]            i_data,
    input  wire logic                         i_user,
    input  wire logic                         i_advance,
    output logic                              o_valid,
    output t_op                               o_op,
    output logic signed [COORD_BITS-1:0]      o_x_start,
    output logic signed [COORD_BITS-1:0]      o_y_start,
    output logic signed [COORD_BITS-1:0]      o_x_end,
    output logic signed [COORD_BITS-1:0]      o_y_end,
    output logic [COLOR_BITS-1:0]             o_color
);

    logic                 r_valid;
    logic [DATA_W-1:0]    r_data;
    logic                 r_user;

    // Take a new item when empty or whenever the held one moves on this cycle
    assign o_ready = !r_valid || i_advance;

    // Hold valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
            r_user <= i_user;
        end
    end

    // Unpack fields, first field in the lowest bits
    assign o_valid   = r_valid;
    assign o_op      = t_op'(r_user);
    assign o_x_start = r_data[0*COORD_BITS +: COORD_BITS];
    assign o_y_start = r_data[1*COORD_BITS +: COORD_BITS];
    assign o_x_end   = r_data[2*COORD_BITS +: COORD_BITS];
    assign o_y_end   = r_data[3*COORD_BITS +: COORD_BITS];
    assign o_color   = r_data[4*COORD_BITS +: COLOR_BITS];

endmodule

`default_nettype wire

// File: hdl/brl_engine.sv
// Line state and the per-item load or step logic of the rasterizer.
`default_nettype none

module brl_engine
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic                         i_advance,
    input  wire t_op                          i_op,
    input  wire logic signed [COORD_BITS-1:0] i_x_start,
    input  wire logic signed [COORD_BITS-1:0] i_y_start,
    input  wire logic signed [COORD_BITS-1:0] i_x_end,
    input  wire logic signed [COORD_BITS-1:0] i_y_end,
    input  wire logic [COLOR_BITS-1:0]        i_color,
    output logic                              o_res_valid,
    output logic [COORD_BITS-1:0]             o_pixel_x,
    output logic [COORD_BITS-1:0]             o_pixel_y,
    output logic [COLOR_BITS-1:0]             o_pixel_color,
    output logic                              o_last
);

    localparam int N = COORD_BITS;

    // Line state
    logic                 r_busy;
    logic [N-1:0]         r_x;
    logic [N-1:0]         r_y;
    logic signed [N+2:0]  r_err;
    logic [N-1:0]         r_steps;
    logic                 r_minor_neg;
    logic                 r_x_major;
    logic [N:0]           r_inc_str;
    logic signed [N+1:0]  r_inc_diag;
    logic [COLOR_BITS-1:0] r_color;

    logic                 n_busy;
    logic [N-1:0]         n_x;
    logic [N-1:0]         n_y;
    logic signed [N+2:0]  n_err;
    logic [N-1:0]         n_steps;
    logic                 n_minor_neg;
    logic                 n_x_major;
    logic [N:0]           n_inc_str;
    logic signed [N+1:0]  n_inc_diag;
    logic [COLOR_BITS-1:0] n_color;

    // Load datapath
    logic signed [N:0]    dx_full;
    logic signed [N:0]    dy_full;
    logic [N-1:0]         dx;
    logic [N-1:0]         dy;
    logic                 x_major;
    logic                 x_fwd;
    logic                 y_fwd;
    logic                 same_point;
    logic [N-1:0]         major;
    logic [N-1:0]         minor;
    logic signed [N:0]    minor_less_major;

    // Step datapath
    logic                 diag;
    logic [N-1:0]         minor_coord;
    logic [N-1:0]         steps_dec;

    logic                 take;

    assign take = i_valid && i_advance;

    // Distances along each axis
    always_comb begin
        dx_full    = {i_x_end[N-1], i_x_end} - {i_x_start[N-1], i_x_start};
        dy_full    = {i_y_end[N-1], i_y_end} - {i_y_start[N-1], i_y_start};
        dx         = dx_full[N] ? N'(-dx_full) : dx_full[N-1:0];
        dy         = dy_full[N] ? N'(-dy_full) : dy_full[N-1:0];
        x_major    = dx >= dy;
        x_fwd      = i_x_start < i_x_end;
        y_fwd      = i_y_start < i_y_end;
        same_point = (i_x_start == i_x_end) && (i_y_start == i_y_end);
        major      = x_major ? dx : dy;
        minor      = x_major ? dy : dx;
        minor_less_major = {1'b0, minor} - {1'b0, major};
    end

    // Step decision and the moved minor coordinate
    always_comb begin
        diag        = !r_err[N+2];
        minor_coord = r_x_major ? r_y : r_x;
        if (diag) begin
            minor_coord = r_minor_neg ? minor_coord - N'(1) : minor_coord + N'(1);
        end
        steps_dec = r_steps - N'(1);
    end

    // Next state and the result of this item
    always_comb begin
        n_busy      = r_busy;
        n_x         = r_x;
        n_y         = r_y;
        n_err       = r_err;
        n_steps     = r_steps;
        n_minor_neg = r_minor_neg;
        n_x_major   = r_x_major;
        n_inc_str   = r_inc_str;
        n_inc_diag  = r_inc_diag;
        n_color     = r_color;
        o_res_valid = 1'b0;
        o_last      = 1'b0;

        if (i_op == OP_LOAD) begin
            o_res_valid = i_valid;
            n_color     = i_color;
            if (same_point) begin
                n_x     = i_x_start;
                n_y     = i_y_start;
                n_steps = '0;
                n_busy  = 1'b0;
                o_last  = 1'b1;
            end else begin
                // Start at the end with the smaller major coordinate
                if (x_major ? x_fwd : y_fwd) begin
                    n_x = i_x_start;
                    n_y = i_y_start;
                end else begin
                    n_x = i_x_end;
                    n_y = i_y_end;
                end
                if (x_major) begin
                    n_minor_neg = x_fwd ? (i_y_end < i_y_start) : y_fwd;
                end else begin
                    n_minor_neg = y_fwd ? (i_x_end < i_x_start) : x_fwd;
                end
                n_x_major  = x_major;
                n_inc_str  = {minor, 1'b0};
                n_inc_diag = {minor_less_major, 1'b0};
                n_err      = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
                n_steps    = major;
                n_busy     = 1'b1;
            end
        end else if (r_busy) begin
            o_res_valid = i_valid;
            n_err = diag ? r_err + {r_inc_diag[N+1], r_inc_diag}
                         : r_err + $signed({2'b00, r_inc_str});
            if (r_x_major) begin
                n_x = r_x + N'(1);
                n_y = minor_coord;
            end else begin
                n_y = r_y + N'(1);
                n_x = minor_coord;
            end
            n_steps = steps_dec;
            n_busy  = steps_dec != '0;
            o_last  = steps_dec == '0;
        end

        o_pixel_x     = n_x;
        o_pixel_y     = n_y;
        o_pixel_color = n_color;
    end

    // Busy flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_busy <= n_busy;
        end
    end

    // Advance the line state on each taken item
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_x         <= n_x;
            r_y         <= n_y;
            r_err       <= n_err;
            r_steps     <= n_steps;
            r_minor_neg <= n_minor_neg;
            r_x_major   <= n_x_major;
            r_inc_str   <= n_inc_str;
            r_inc_diag  <= n_inc_diag;
            r_color     <= n_color;
        end
    end

endmodule

`default_nettype wire

// File: hdl/brl_out_stage.sv
// Result register: holds one pixel item and packs it onto the output stream.
`default_nettype none

module brl_out_stage
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int DATA_W     = 56
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_res_valid,
    input  wire logic [COORD_BITS-1:0] i_pixel_x,
    input  wire logic [COORD_BITS-1:0] i_pixel_y,
    input  wire logic [COLOR_BITS-1:0] i_pixel_color,
    input  wire logic                  i_last,
    output logic                       o_advance,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [DATA_W-1:0]          o_data,
    output logic                       o_last
);

    localparam int PAY_W = 2 * COORD_BITS + COLOR_BITS;

    logic              r_valid;
    logic [PAY_W-1:0]  r_pay;
    logic              r_last;

    // The register frees when empty or when its item is taken
    assign o_advance = !r_valid || i_ready;

    // Hold valid under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    // Load the pixel
    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_pay  <= {i_pixel_color, i_pixel_y, i_pixel_x};
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = DATA_W'(r_pay);
    assign o_last  = r_last;

endmodule

`default_nettype wire

// File: hdl/bresenham_line_rasterizer_core.sv
// Top level of the Bresenham line rasterizer.
//
//  channel   dir  tdata (low bit up)                          tuser / tlast
//  s_axis    in   x_start, y_start, x_end, y_end, color, pad  tuser: operation
//  m_axis    out  pixel_x, pixel_y, pixel_color, pad          tlast: last_pixel
//
// One item enters per clock while m_axis does not stall; a pixel is presented on m_axis
// from the result register: the accepting edge loads the input register, and the result
// register takes the pixel through the single pass of add/compare logic between them
// when it frees. Step items while idle produce nothing.
// Reset (i_rst_n low, synchronous) empties both registers and makes the block
// idle. A stall on m_axis holds the result register and backs up into s_axis.
`default_nettype none

module bresenham_line_rasterizer_core
    import brl_pkg::*;
#(
    parameter int COORD_BITS = 16,
    localparam int IN_W  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // x_start, y_start, x_end, y_end, color
    input  wire logic             s_axis_tuser,   // operation
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // pixel_x, pixel_y, pixel_color
    output logic                  m_axis_tlast    // last_pixel
);

    logic                         advance;
    logic                         in_valid;
    t_op                          in_op;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0]        color;
    logic                         res_valid;
    logic [COORD_BITS-1:0]        pixel_x;
    logic [COORD_BITS-1:0]        pixel_y;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         last;

    brl_in_stage #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (IN_W)
    ) u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata),
        .i_user     (s_axis_tuser),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_op       (in_op),
        .o_x_start  (x_start),
        .o_y_start  (y_start),
        .o_x_end    (x_end),
        .o_y_end    (y_end),
        .o_color    (color)
    );

    brl_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid),
        .i_advance     (advance),
        .i_op          (in_op),
        .i_x_start     (x_start),
        .i_y_start     (y_start),
        .i_x_end       (x_end),
        .i_y_end       (y_end),
        .i_color       (color),
        .o_res_valid   (res_valid),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_pixel_color (pixel_color),
        .o_last        (last)
    );

    brl_out_stage #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (OUT_W)
    ) u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res_valid   (res_valid),
        .i_pixel_x     (pixel_x),
        .i_pixel_y     (pixel_y),
        .i_pixel_color (pixel_color),
        .i_last        (last),
        .o_advance     (advance),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

endmodule

`default_nettype wire
